@@ rtl/core/vfd_text_scroll_refresh_engine_macros.svh @@
// Assertion macros for the VFD text/scroll/refresh engine.
// Used by the RTL in rtl/core; define SYNTH to compile them away.
`ifndef VFD_TEXT_SCROLL_REFRESH_ENGINE_MACROS_SVH
`define VFD_TEXT_SCROLL_REFRESH_ENGINE_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset
`define VTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vfdts: assertion failed");
// Check that a condition is followed by another in the next cycle
`define VTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfdts: assertion failed");
`else
`define VTS_ASSERT(lbl, clk, rst_n, prop)
`define VTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/vfdts_pkg.sv @@
// Shared types, codes, constant tables and helper functions of the VFD engine.
// No dependencies; imported by every module in rtl/core.
package vfdts_pkg;

  // Default configuration of the top level
  localparam int DIGITS_DEF  = 10;
  localparam int SYMBOLS_DEF = 22;
  localparam int GRIDS_DEF   = 12;

  // Grid index field width in commands (GRIDS is at most 16)
  localparam int GRID_IDX_W = 4;

  // Item modes
  localparam logic [2:0] MODE_TEXT        = 3'd0;
  localparam logic [2:0] MODE_SCROLL_TEXT = 3'd1;
  localparam logic [2:0] MODE_SYMBOL      = 3'd2;
  localparam logic [2:0] MODE_SCROLL      = 3'd3;
  localparam logic [2:0] MODE_REFRESH     = 3'd4;
  localparam logic [2:0] MODE_INIT        = 3'd5;

  // Register indexes
  localparam logic REG_DUTY          = 1'b0;
  localparam logic REG_TRANSFER_MODE = 1'b1;

  // Transfer modes
  localparam logic [1:0] TM_NONE       = 2'd0;
  localparam logic [1:0] TM_PAIRS      = 2'd1;
  localparam logic [1:0] TM_BURST      = 2'd2;
  localparam logic [1:0] TM_PAIRS_CTRL = 2'd3;

  // Controller command bytes
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h88;
  localparam logic [7:0] CMD_MODE = 8'h0B;
  localparam logic [7:0] DUTY_MAX = 8'd15;

  // Start-up sequence length of the zero run
  localparam int INIT_ZEROS = 36;
  localparam int ZW         = $clog2(INIT_ZEROS);

  // Character codes with glyphs
  localparam logic [7:0] CHAR_RAW_LIMIT = 8'd10;
  localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'd90;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9   = 8'd57;
  localparam logic [7:0] CHAR_ALPHA_OFS = 8'd55;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [5:0] GLYPH_PLUS     = 6'd36;
  localparam logic [5:0] GLYPH_MINUS    = 6'd37;
  localparam logic [5:0] GLYPH_STAR     = 6'd38;
  localparam logic [5:0] GLYPH_SLASH    = 6'd39;
  localparam logic [5:0] GLYPH_COMMA    = 6'd47;

  localparam int GLYPH_N = 48;

  // Glyph ROM, first and second byte of each pattern
  localparam logic [7:0] GLYPH_LO [GLYPH_N] = '{
    8'h8C, 8'h80, 8'h0C, 8'h84, 8'h80, 8'h84, 8'h8C, 8'h80, 8'h8C, 8'h84, 8'h88, 8'hA4,
    8'h0C, 8'hA4, 8'h0C, 8'h08, 8'h8C, 8'h88, 8'h24, 8'h84, 8'h48, 8'h0C, 8'h88, 8'hC8,
    8'h8C, 8'h08, 8'hCC, 8'h48, 8'h84, 8'h20, 8'h8C, 8'h8C, 8'hAC, 8'h50, 8'h20, 8'h14,
    8'h20, 8'h00, 8'h70, 8'h10, 8'h40, 8'h08, 8'h20, 8'h80, 8'hA8, 8'h28, 8'hA0, 8'h10
  };
  localparam logic [7:0] GLYPH_HI [GLYPH_N] = '{
    8'hC4, 8'h40, 8'hC3, 8'hC3, 8'h47, 8'h87, 8'h87, 8'hC0, 8'hC7, 8'hC7, 8'hC7, 8'hD1,
    8'h84, 8'hD0, 8'h86, 8'h86, 8'h85, 8'h47, 8'h90, 8'h40, 8'h26, 8'h04, 8'h6C, 8'h4C,
    8'hC4, 8'hC7, 8'hC4, 8'hC7, 8'h87, 8'h90, 8'h44, 8'h44, 8'h44, 8'h28, 8'h28, 8'hA0,
    8'h13, 8'h03, 8'h3B, 8'h20, 8'h08, 8'h04, 8'h10, 8'h40, 8'h54, 8'h14, 8'h50, 8'h00
  };

  // Fixed symbol bits: grid, byte half and mask of each symbol
  localparam int SYM_MAP_N = 22;
  localparam logic [2:0] SYM_GRID [SYM_MAP_N] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };
  localparam logic SYM_HI [SYM_MAP_N] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };
  localparam logic [7:0] SYM_MASK [SYM_MAP_N] = '{
    8'h08, 8'h10, 8'h20, 8'h40, 8'h01, 8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02,
    8'h01, 8'h02, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  // Kinds of byte the datapath can put out
  typedef enum logic [2:0] {
    K_DATA_CMD,
    K_ADDR_CMD,
    K_GRID_ADDR,
    K_GRID_DATA,
    K_ZERO,
    K_MODE,
    K_CTRL,
    K_INIT_CTRL
  } emit_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic                  apply;
    logic                  step;
    logic                  clear;
    logic                  load;
    emit_kind_e            kind;
    logic [GRID_IDX_W-1:0] grid;
    logic                  half;
    logic                  last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] transfer_mode;
  } dp_sts_t;

  // Look up one byte of a character's glyph; codes without a glyph show blank
  function automatic logic [7:0] glyph_byte(input logic [7:0] c, input logic half);
    logic [5:0] idx;
    logic       hit;
    hit = 1'b1;
    idx = '0;
    if (c < CHAR_RAW_LIMIT) begin
      idx = c[5:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      idx = 6'(c - CHAR_ALPHA_OFS);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      idx = 6'(c - CHAR_DIGIT_0);
    end else if (c == CHAR_PLUS) begin
      idx = GLYPH_PLUS;
    end else if (c == CHAR_MINUS) begin
      idx = GLYPH_MINUS;
    end else if (c == CHAR_STAR) begin
      idx = GLYPH_STAR;
    end else if (c == CHAR_SLASH) begin
      idx = GLYPH_SLASH;
    end else if (c == CHAR_COMMA) begin
      idx = GLYPH_COMMA;
    end else begin
      hit = 1'b0;
    end
    if (!hit) begin
      return 8'h00;
    end
    return half ? GLYPH_HI[idx] : GLYPH_LO[idx];
  endfunction

endpackage

@@ rtl/core/vfd_text_scroll_refresh_engine.sv @@
// Text, scroll and symbol items are applied to the state registers on acceptance; a
// refresh first makes its scroll step, then its bytes pass through the output register,
// one byte per cycle while out_ready_i is high. A refresh sends 48 bytes (pairs), 49
// (pairs plus control) or 40 (burst); init sends 40. A new item is accepted only in idle.
// Reset: text and scroll text to spaces, symbols and scroll state cleared, duty 0,
// transfer mode 3; ready as soon as reset is released, no clearing pass.
module vfd_text_scroll_refresh_engine #(
  parameter int DIGITS  = vfdts_pkg::DIGITS_DEF,
  parameter int SYMBOLS = vfdts_pkg::SYMBOLS_DEF,
  parameter int GRIDS   = vfdts_pkg::GRIDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        mode_i,
  input  logic [3:0]        position_i,
  input  logic [7:0]        char_code_i,
  input  logic [4:0]        symbol_index_i,
  input  logic              symbol_on_i,
  input  logic signed [7:0] scroll_speed_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        serial_byte_o,
  output logic              frame_start_o,
  output logic              last_o
);
  import vfdts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  vfdts_ctrl #(
    .GRIDS (GRIDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // State, pattern build and output register
  vfdts_dp #(
    .DIGITS  (DIGITS),
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .char_code_i    (char_code_i),
    .symbol_index_i (symbol_index_i),
    .symbol_on_i    (symbol_on_i),
    .scroll_speed_i (scroll_speed_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .serial_byte_o  (serial_byte_o),
    .frame_start_o  (frame_start_o),
    .last_o         (last_o)
  );

endmodule

@@ rtl/core/vfdts_dp.sv @@
// Datapath of the VFD engine: text, scroll and symbol state, config registers,
// glyph/symbol pattern build and the output byte register. Uses vfdts_pkg.
module vfdts_dp #(
  parameter int DIGITS  = vfdts_pkg::DIGITS_DEF,
  parameter int SYMBOLS = vfdts_pkg::SYMBOLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic [2:0]          mode_i,
  input  logic [3:0]          position_i,
  input  logic [7:0]          char_code_i,
  input  logic [4:0]          symbol_index_i,
  input  logic                symbol_on_i,
  input  logic signed [7:0]   scroll_speed_i,
  input  vfdts_pkg::dp_cmd_t  cmd_i,
  output vfdts_pkg::dp_sts_t  sts_o,
  output logic [7:0]          serial_byte_o,
  output logic                frame_start_o,
  output logic                last_o
);
  import vfdts_pkg::*;

  localparam int DW = $clog2(DIGITS + 1);
  localparam int SW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int YW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [7:0] SPACE = 8'h20;

  logic [7:0]         disp_q [DIGITS+1];
  logic [7:0]         disp_d [DIGITS+1];
  logic [7:0]         scr_q  [DIGITS];
  logic [7:0]         scr_d  [DIGITS];
  logic [SYMBOLS-1:0] sym_q, sym_d;
  logic [DW-1:0]      cnt_q, cnt_d;
  logic [7:0]         wait_q, wait_d;
  logic [7:0]         rate_q, rate_d;
  logic [7:0]         duty_q;
  logic [1:0]         tm_q;
  logic [7:0]         byte_q;
  logic               frame_q;
  logic               last_q;

  logic [7:0]    abs_wait;
  logic [DW-1:0] ridx;
  logic [DW-1:0] sidx;
  logic [7:0]    feed;
  logic [4:0]    pos_ext;
  logic [5:0]    diff;
  logic          gshow;
  logic [7:0]    ch;
  logic [7:0]    pat;
  logic [31:0]   sym_ext;
  logic [7:0]    ctrl_byte;
  logic [7:0]    g8;
  logic [7:0]    addr_byte;
  logic [7:0]    byte_d;
  logic          frame_d;

  // Scroll source: one read of the scroll text per step
  assign abs_wait = rate_q[7] ? (8'd0 - rate_q) : rate_q;
  assign ridx     = DW'(DIGITS - 1) - cnt_q;
  assign sidx     = rate_q[7] ? ridx : cnt_q;
  assign feed     = scr_q[sidx[SW-1:0]];
  assign pos_ext  = 5'(position_i);

  // Next state of text, scroll and symbols
  always_comb begin
    disp_d = disp_q;
    scr_d  = scr_q;
    sym_d  = sym_q;
    cnt_d  = cnt_q;
    wait_d = wait_q;
    rate_d = rate_q;
    if (cmd_i.clear) begin
      for (int i = 0; i <= DIGITS; i++) disp_d[i] = SPACE;
      for (int i = 0; i < DIGITS; i++) scr_d[i] = SPACE;
      sym_d  = '0;
      cnt_d  = '0;
      wait_d = '0;
      rate_d = '0;
    end else if (cmd_i.apply) begin
      case (mode_i)
        MODE_TEXT: begin
          if (pos_ext < 5'(DIGITS)) disp_d[pos_ext[DW-1:0]] = char_code_i;
        end
        MODE_SCROLL_TEXT: begin
          if (pos_ext < 5'(DIGITS)) scr_d[position_i[SW-1:0]] = char_code_i;
        end
        MODE_SYMBOL: begin
          if (6'(symbol_index_i) < 6'(SYMBOLS)) sym_d[symbol_index_i[YW-1:0]] = symbol_on_i;
        end
        MODE_SCROLL: begin
          cnt_d  = '0;
          wait_d = '0;
          rate_d = scroll_speed_i;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.step && rate_q != 8'd0) begin
      if (cnt_q >= DW'(DIGITS)) begin
        // scroll finished: stop
        cnt_d  = '0;
        wait_d = '0;
        rate_d = '0;
      end else if (wait_q <= abs_wait) begin
        wait_d = wait_q + 8'd1;
      end else begin
        // shift one place towards the scroll direction
        for (int i = 0; i <= DIGITS; i++) begin
          if (!rate_q[7]) begin
            if (i < DIGITS - 1) disp_d[i] = disp_q[i+1];
            else disp_d[i] = feed;
          end else begin
            if (i == 0) disp_d[i] = feed;
            else disp_d[i] = disp_q[i-1];
          end
        end
        wait_d = '0;
        cnt_d  = cnt_q + DW'(1);
      end
    end
  end

  // Pattern of the current grid: glyph plus fixed symbol bits
  assign diff    = 6'(DIGITS) - 6'(cmd_i.grid);
  assign gshow   = (cmd_i.grid != '0) && (5'(cmd_i.grid) <= 5'(DIGITS));
  assign ch      = disp_q[diff[DW-1:0]];
  assign sym_ext = 32'(sym_q);

  always_comb begin
    pat = gshow ? glyph_byte(ch, cmd_i.half) : 8'h00;
    for (int s = 0; s < SYM_MAP_N; s++) begin
      if (sym_ext[s] && (4'(SYM_GRID[s]) == cmd_i.grid) && (SYM_HI[s] == cmd_i.half)) begin
        pat = pat | SYM_MASK[s];
      end
    end
  end

  // Output byte selection
  assign ctrl_byte = (duty_q >= 8'd1 && duty_q <= DUTY_MAX) ? (CMD_CTRL + duty_q) : CMD_CTRL;
  assign g8        = 8'(cmd_i.grid);
  assign addr_byte = CMD_ADDR | ((g8 << 1) + g8 + 8'(cmd_i.half));

  always_comb begin
    case (cmd_i.kind)
      K_DATA_CMD:  begin byte_d = CMD_DATA;  frame_d = 1'b1; end
      K_ADDR_CMD:  begin byte_d = CMD_ADDR;  frame_d = 1'b1; end
      K_GRID_ADDR: begin byte_d = addr_byte; frame_d = 1'b1; end
      K_GRID_DATA: begin byte_d = pat;       frame_d = 1'b0; end
      K_ZERO:      begin byte_d = 8'h00;     frame_d = 1'b0; end
      K_MODE:      begin byte_d = CMD_MODE;  frame_d = 1'b1; end
      K_CTRL:      begin byte_d = ctrl_byte; frame_d = 1'b1; end
      K_INIT_CTRL: begin byte_d = CMD_CTRL;  frame_d = 1'b1; end
      default:     begin byte_d = 8'h00;     frame_d = 1'b0; end
    endcase
  end

  // Hold display state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIGITS; i++) disp_q[i] <= SPACE;
      for (int i = 0; i < DIGITS; i++) scr_q[i] <= SPACE;
      sym_q  <= '0;
      cnt_q  <= '0;
      wait_q <= '0;
      rate_q <= '0;
      duty_q <= '0;
      tm_q   <= TM_PAIRS_CTRL;
    end else begin
      disp_q <= disp_d;
      scr_q  <= scr_d;
      sym_q  <= sym_d;
      cnt_q  <= cnt_d;
      wait_q <= wait_d;
      rate_q <= rate_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DUTY:          duty_q <= cfg_wdata_i;
          REG_TRANSFER_MODE: tm_q   <= cfg_wdata_i[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q  <= byte_d;
      frame_q <= frame_d;
      last_q  <= cmd_i.last;
    end
  end

  assign sts_o.transfer_mode = tm_q;
  assign serial_byte_o       = byte_q;
  assign frame_start_o       = frame_q;
  assign last_o              = last_q;

endmodule

@@ rtl/core/vfdts_ctrl.sv @@
// Controller of the VFD engine: item decode and the byte sequencer for
// refresh and start-up. Uses vfdts_pkg and the assertion macros header.
module vfdts_ctrl #(
  parameter int GRIDS = vfdts_pkg::GRIDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  vfdts_pkg::dp_sts_t sts_i,
  output vfdts_pkg::dp_cmd_t cmd_o
);
  import vfdts_pkg::*;
  `include "vfd_text_scroll_refresh_engine_macros.svh"

  localparam int GW = $clog2(GRIDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_HEAD0,
    ST_HEAD1,
    ST_BODY,
    ST_ZERO,
    ST_MODE,
    ST_CTRL
  } state_e;

  state_e        state_q, state_d;
  logic [GW-1:0] grid_q, grid_d;
  logic [1:0]    sub_q, sub_d;
  logic [ZW-1:0] zcnt_q, zcnt_d;
  logic          init_q, init_d;
  logic          out_valid_q, out_valid_d;
  logic          slot_free;
  logic          accept;
  logic          grid_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign grid_end   = (grid_q == GW'(GRIDS - 1));

  // Sequence the item and drive datapath commands
  always_comb begin
    state_d     = state_q;
    grid_d      = grid_q;
    sub_d       = sub_q;
    zcnt_d      = zcnt_q;
    init_d      = init_q;
    cmd_o       = '0;
    cmd_o.kind  = K_ZERO;
    cmd_o.grid  = GRID_IDX_W'(grid_q);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_REFRESH: state_d = ST_STEP;
            MODE_INIT: begin
              cmd_o.clear = 1'b1;
              init_d      = 1'b1;
              state_d     = ST_HEAD0;
            end
            MODE_TEXT, MODE_SCROLL_TEXT, MODE_SYMBOL, MODE_SCROLL: cmd_o.apply = 1'b1;
            default: begin
            end
          endcase
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        init_d     = 1'b0;
        grid_d     = '0;
        sub_d      = '0;
        case (sts_i.transfer_mode)
          TM_PAIRS, TM_PAIRS_CTRL: state_d = ST_BODY;
          TM_BURST:                state_d = ST_HEAD0;
          default:                 state_d = ST_IDLE;
        endcase
      end
      ST_HEAD0: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = K_DATA_CMD;
          state_d    = ST_HEAD1;
        end
      end
      ST_HEAD1: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = K_ADDR_CMD;
          state_d    = init_q ? ST_ZERO : ST_BODY;
        end
      end
      ST_BODY: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.transfer_mode == TM_BURST) begin
            // low, high, then a zero pad byte per grid
            cmd_o.kind = (sub_q == 2'd2) ? K_ZERO : K_GRID_DATA;
            cmd_o.half = sub_q[0];
            if (sub_q == 2'd2) begin
              sub_d = '0;
              if (grid_end) state_d = ST_MODE;
              else grid_d = grid_q + GW'(1);
            end else begin
              sub_d = sub_q + 2'd1;
            end
          end else begin
            // address and data for low, then for high
            cmd_o.kind = sub_q[0] ? K_GRID_DATA : K_GRID_ADDR;
            cmd_o.half = sub_q[1];
            sub_d      = sub_q + 2'd1;
            if (sub_q == 2'd3 && grid_end) begin
              if (sts_i.transfer_mode == TM_PAIRS_CTRL) begin
                state_d = ST_CTRL;
              end else begin
                cmd_o.last = 1'b1;
                state_d    = ST_IDLE;
              end
            end else if (sub_q == 2'd3) begin
              grid_d = grid_q + GW'(1);
            end
          end
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = K_ZERO;
          if (zcnt_q == ZW'(INIT_ZEROS - 1)) begin
            zcnt_d  = '0;
            state_d = ST_MODE;
          end else begin
            zcnt_d = zcnt_q + ZW'(1);
          end
        end
      end
      ST_MODE: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = K_MODE;
          state_d    = ST_CTRL;
        end
      end
      ST_CTRL: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = init_q ? K_INIT_CTRL : K_CTRL;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Hold state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_q      <= '0;
      sub_q       <= '0;
      zcnt_q      <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_q      <= grid_d;
      sub_q       <= sub_d;
      zcnt_q      <= zcnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A beat is only loaded into a free or draining output register
  `VTS_ASSERT(a_load_slot_free, clk_i, rst_ni, !cmd_o.load || !out_valid_q || out_ready_i)
  // Grid and zero-run counters stay inside their sequences
  `VTS_ASSERT(a_grid_range, clk_i, rst_ni, grid_q <= GW'(GRIDS - 1))
  `VTS_ASSERT(a_zero_range, clk_i, rst_ni, zcnt_q <= ZW'(INIT_ZEROS - 1))
  // A refresh always begins with its scroll step
  `VTS_ASSERT_NEXT(a_refresh_steps, clk_i, rst_ni, accept && (mode_i == MODE_REFRESH), state_q == ST_STEP)
  // The final beat of an item returns the sequencer to idle
  `VTS_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, cmd_o.load && cmd_o.last, state_q == ST_IDLE)

endmodule
